### hdl/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg: shared definitions of the template matcher
// sizes, fixed-point constants, sequencer states and control types
// ----------------------------------------------------------------------------
`default_nettype none

package tma_pkg;

	// table sizes
	localparam int MAX_TEMPLATES = 64;
	localparam int VECTOR_LENGTH = 10;

	// derived widths
	localparam int IDX_W  = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
	localparam int CNT_W  = $clog2(MAX_TEMPLATES + 1);
	localparam int CYC_W  = $clog2(VECTOR_LENGTH + 2);
	localparam int WA_W   = $clog2(MAX_TEMPLATES * VECTOR_LENGTH);
	localparam int OUT_W  = 7;

	// datapath widths
	localparam int COMP_W  = 16;
	localparam int ACC_W   = 36;
	localparam int SCORE_W = 54;
	localparam int MA_W    = 19;
	localparam int MB_W    = 18;
	localparam int MP_W    = MA_W + MB_W;

	// iteration counts of the root, divider and log units
	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 16;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam int LN_FRAC    = 12;

	// constants
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [15:0] AGE_NEW = 16'd2;
	localparam logic [15:0] AGE_WIN = 16'd1;
	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	typedef logic signed [COMP_W-1:0] comp_t;

	// action codes
	typedef enum logic [1:0] {
		ACT_MATCH = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADD_SQ,
		ST_ADD_RSTART,
		ST_ADD_ROOT,
		ST_ADD_DSTART,
		ST_ADD_DIV,
		ST_ADD_WR,
		ST_ADD_AGE,
		ST_MT_NEXT,
		ST_MT_DOT,
		ST_MT_POST,
		ST_MT_AGE_RD,
		ST_MT_AGE_LD,
		ST_MT_SQ_MUL,
		ST_MT_SQ_NORM,
		ST_MT_LN_MUL,
		ST_MT_LN_RND,
		ST_MT_SC_LO,
		ST_MT_SC_HI,
		ST_MT_SC_SUM,
		ST_MT_CMP,
		ST_AG_RD,
		ST_AG_WR,
		ST_RESP
	} state_t;

	// commands to the root / divide unit
	typedef struct packed {
		logic start_root;
		logic start_div;
	} rd_ctl_t;

endpackage

`default_nettype wire

### hdl/tma_if.sv
// ----------------------------------------------------------------------------
// tma_if: valid/ready channels of the template matcher
// command channel (action and vector) and result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface tma_cmd_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic signed [15:0]    component_0;
	logic signed [15:0]    component_1;
	logic signed [15:0]    component_2;
	logic signed [15:0]    component_3;
	logic signed [15:0]    component_4;
	logic signed [15:0]    component_5;
	logic signed [15:0]    component_6;
	logic signed [15:0]    component_7;
	logic signed [15:0]    component_8;
	logic signed [15:0]    component_9;

	modport source (
		output valid, action, component_0, component_1, component_2, component_3,
		       component_4, component_5, component_6, component_7, component_8,
		       component_9,
		input  ready
	);
	modport sink (
		input  valid, action, component_0, component_1, component_2, component_3,
		       component_4, component_5, component_6, component_7, component_8,
		       component_9,
		output ready
	);
endinterface

interface tma_res_if;
	logic              valid;
	logic              ready;
	logic signed [6:0] best_index;
	logic              status;
	logic [6:0]        stored_count;

	modport source (output valid, best_index, status, stored_count, input ready);
	modport sink (input valid, best_index, status, stored_count, output ready);
endinterface

`default_nettype wire

### hdl/template_match_with_aging.sv
// ----------------------------------------------------------------------------
// template_match_with_aging: cosine-similarity template matcher with aging
// sequencer, template and age memories around one shared multiplier
// ----------------------------------------------------------------------------
// Usage
//   cmd: one transfer per item (action, component_0..9). res: one transfer
//   per item (best_index, status, stored_count). cfg_we/cfg_wdata write
//   nonrepeat; the user must write it only while the block is idle (not enforced).
//   Items are handled one at a time; cmd.ready is high only when idle.
//   Steps from command transfer to result, N stored templates:
//     clear or undefined action: decode, then result
//     add: squares, bit-serial root, then one 16-step divide and a write
//          per element, then the age write
//     match: a dot product per template, with nonrepeat also the log unit
//          (12 squarings, each a multiply and a normalize state) and the
//          score product; then the age update of all N templates when there is a winner
//   All products go through the one multiplier; the root and divide share
//   one bit-serial unit.
//   Reset clears the template count and nonrepeat; memories are not cleared.
//   A result waits in its registers while res.ready is low; no new command
//   is taken until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module template_match_with_aging (
	input  wire logic         clk,
	input  wire logic         arst_n,
	tma_cmd_if.sink           cmd,
	tma_res_if.source         res,
	input  wire logic         cfg_we,
	input  wire logic         cfg_wdata
);

	localparam int VL = tma_pkg::VECTOR_LENGTH;
	localparam int MT = tma_pkg::MAX_TEMPLATES;

	// state
	tma_pkg::state_t                  state_q, state_d;
	logic [1:0]                       act_q;
	tma_pkg::comp_t                   x_q [VL];
	logic                             nonrepeat_q;
	logic [tma_pkg::CNT_W-1:0]        count_q;
	logic [tma_pkg::CNT_W-1:0]        tpl_q;
	logic [tma_pkg::CYC_W-1:0]        cyc_q;
	logic [tma_pkg::CYC_W-1:0]        elem_q;
	logic [3:0]                       iter_q;
	logic signed [tma_pkg::ACC_W-1:0] acc_q;
	logic signed [tma_pkg::SCORE_W-1:0] score_q;
	logic signed [tma_pkg::SCORE_W-1:0] best_q;
	logic                             found_q;
	logic [tma_pkg::IDX_W-1:0]        win_q;
	logic [15:0]                      m_q;
	logic [tma_pkg::LN_FRAC-1:0]      frac_q;
	logic [3:0]                       e_q;
	logic [15:0]                      ln_q;
	logic                             status_q;

	// memories
	logic signed [15:0] wmem [MT * VL];
	logic [15:0]        amem [MT];
	logic signed [15:0] w_rd_q;
	logic [15:0]        a_rd_q;

	// control decode
	logic                              w_re, w_we, a_re, a_we;
	logic [tma_pkg::WA_W-1:0]          w_addr;
	logic signed [15:0]                w_wdata;
	logic [tma_pkg::IDX_W-1:0]         a_addr;
	logic [15:0]                       a_wdata;
	logic signed [tma_pkg::MA_W-1:0]   mul_a;
	logic signed [tma_pkg::MB_W-1:0]   mul_b;
	logic signed [tma_pkg::MP_W-1:0]   mul_p;
	tma_pkg::rd_ctl_t                  rd_ctl;
	logic                              rd_done;
	logic [15:0]                       quot;
	logic [tma_pkg::CYC_W-1:0]         elsel;
	tma_pkg::comp_t                    xsel;
	logic [15:0]                       mag;
	logic                              table_full;
	logic [tma_pkg::WA_W-1:0]          tpl_base, add_base;
	logic [3:0]                        e_c;
	logic [15:0]                       m_c;
	logic [16:0]                       sq_t;
	logic [32:0]                       ln_rnd;
	logic signed [tma_pkg::SCORE_W-1:0] prod_ext;
	logic [tma_pkg::IDX_W+tma_pkg::OUT_W-1:0] win_ext;
	logic [tma_pkg::CNT_W+tma_pkg::OUT_W-1:0] cnt_ext;

	// shared units
	tma_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	tma_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rd_ctl),
		.sq     (acc_q[33:0]),
		.mag    (mag),
		.done   (rd_done),
		.quot   (quot)
	);

	// element select
	always_comb begin
		xsel = '0;
		for (int i = 0; i < VL; i++) begin
			if (elsel == tma_pkg::CYC_W'(i)) begin
				xsel = x_q[i];
			end
		end
	end

	assign mag        = xsel[15] ? 16'(~xsel + 1'b1) : xsel;
	assign table_full = (count_q >= tma_pkg::CNT_W'(MT));
	assign tpl_base   = tma_pkg::WA_W'(tpl_q[tma_pkg::IDX_W-1:0] * VL);
	assign add_base   = tma_pkg::WA_W'(count_q[tma_pkg::IDX_W-1:0] * VL);
	assign sq_t       = mul_p[31:15];
	assign ln_rnd     = mul_p[32:0] + 33'd32768;
	assign prod_ext   = tma_pkg::SCORE_W'(mul_p);

	// msb position and normalized mantissa of the age
	always_comb begin
		e_c = '0;
		for (int i = 0; i < 16; i++) begin
			if (a_rd_q[i]) begin
				e_c = 4'(i);
			end
		end
		m_c = a_rd_q << (4'd15 - e_c);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tma_pkg::ST_IDLE: begin
				if (cmd.valid) state_d = tma_pkg::ST_DECODE;
			end
			tma_pkg::ST_DECODE: begin
				case (act_q)
					tma_pkg::ACT_MATCH: state_d = tma_pkg::ST_MT_NEXT;
					tma_pkg::ACT_ADD: begin
						state_d = table_full ? tma_pkg::ST_RESP : tma_pkg::ST_ADD_SQ;
					end
					default: state_d = tma_pkg::ST_RESP;
				endcase
			end
			tma_pkg::ST_ADD_SQ: begin
				if (cyc_q == tma_pkg::CYC_W'(VL)) state_d = tma_pkg::ST_ADD_RSTART;
			end
			tma_pkg::ST_ADD_RSTART: state_d = tma_pkg::ST_ADD_ROOT;
			tma_pkg::ST_ADD_ROOT: begin
				if (rd_done) state_d = tma_pkg::ST_ADD_DSTART;
			end
			tma_pkg::ST_ADD_DSTART: state_d = tma_pkg::ST_ADD_DIV;
			tma_pkg::ST_ADD_DIV: begin
				if (rd_done) state_d = tma_pkg::ST_ADD_WR;
			end
			tma_pkg::ST_ADD_WR: begin
				if (elem_q == tma_pkg::CYC_W'(VL - 1)) state_d = tma_pkg::ST_ADD_AGE;
				else state_d = tma_pkg::ST_ADD_DSTART;
			end
			tma_pkg::ST_ADD_AGE: state_d = tma_pkg::ST_RESP;
			tma_pkg::ST_MT_NEXT: begin
				if (tpl_q == count_q) begin
					state_d = found_q ? tma_pkg::ST_AG_RD : tma_pkg::ST_RESP;
				end else begin
					state_d = tma_pkg::ST_MT_DOT;
				end
			end
			tma_pkg::ST_MT_DOT: begin
				if (cyc_q == tma_pkg::CYC_W'(VL + 1)) state_d = tma_pkg::ST_MT_POST;
			end
			tma_pkg::ST_MT_POST: begin
				state_d = nonrepeat_q ? tma_pkg::ST_MT_AGE_RD : tma_pkg::ST_MT_CMP;
			end
			tma_pkg::ST_MT_AGE_RD: state_d = tma_pkg::ST_MT_AGE_LD;
			tma_pkg::ST_MT_AGE_LD: begin
				state_d = (a_rd_q == '0) ? tma_pkg::ST_MT_SC_LO : tma_pkg::ST_MT_SQ_MUL;
			end
			tma_pkg::ST_MT_SQ_MUL: state_d = tma_pkg::ST_MT_SQ_NORM;
			tma_pkg::ST_MT_SQ_NORM: begin
				if (iter_q == 4'(tma_pkg::LN_FRAC - 1)) state_d = tma_pkg::ST_MT_LN_MUL;
				else state_d = tma_pkg::ST_MT_SQ_MUL;
			end
			tma_pkg::ST_MT_LN_MUL: state_d = tma_pkg::ST_MT_LN_RND;
			tma_pkg::ST_MT_LN_RND: state_d = tma_pkg::ST_MT_SC_LO;
			tma_pkg::ST_MT_SC_LO:  state_d = tma_pkg::ST_MT_SC_HI;
			tma_pkg::ST_MT_SC_HI:  state_d = tma_pkg::ST_MT_SC_SUM;
			tma_pkg::ST_MT_SC_SUM: state_d = tma_pkg::ST_MT_CMP;
			tma_pkg::ST_MT_CMP:    state_d = tma_pkg::ST_MT_NEXT;
			tma_pkg::ST_AG_RD:     state_d = tma_pkg::ST_AG_WR;
			tma_pkg::ST_AG_WR: begin
				if (tpl_q + tma_pkg::CNT_W'(1) == count_q) state_d = tma_pkg::ST_RESP;
				else state_d = tma_pkg::ST_AG_RD;
			end
			tma_pkg::ST_RESP: begin
				if (res.ready) state_d = tma_pkg::ST_IDLE;
			end
			default: state_d = tma_pkg::ST_IDLE;
		endcase
	end

	// output decode: multiplier operands, memory ports, unit commands
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		w_re    = 1'b0;
		w_we    = 1'b0;
		w_addr  = tpl_base + tma_pkg::WA_W'(cyc_q);
		w_wdata = '0;
		a_re    = 1'b0;
		a_we    = 1'b0;
		a_addr  = tpl_q[tma_pkg::IDX_W-1:0];
		a_wdata = '0;
		rd_ctl  = '0;
		elsel   = elem_q;
		case (state_q)
			tma_pkg::ST_ADD_SQ: begin
				elsel = cyc_q;
				mul_a = {{3{xsel[15]}}, xsel};
				mul_b = {{2{xsel[15]}}, xsel};
			end
			tma_pkg::ST_ADD_RSTART: rd_ctl.start_root = 1'b1;
			tma_pkg::ST_ADD_DSTART: rd_ctl.start_div = 1'b1;
			tma_pkg::ST_ADD_WR: begin
				w_we   = 1'b1;
				w_addr = add_base + tma_pkg::WA_W'(elem_q);
				if (xsel == '0) begin
					w_wdata = '0;
				end else if (!xsel[15]) begin
					w_wdata = quot[15] ? 16'sh7FFF : quot;
				end else begin
					w_wdata = 16'(~quot + 1'b1);
				end
			end
			tma_pkg::ST_ADD_AGE: begin
				a_we    = 1'b1;
				a_addr  = count_q[tma_pkg::IDX_W-1:0];
				a_wdata = tma_pkg::AGE_NEW;
			end
			tma_pkg::ST_MT_DOT: begin
				w_re  = (cyc_q < tma_pkg::CYC_W'(VL));
				elsel = cyc_q - 1'b1;
				mul_a = {{3{w_rd_q[15]}}, w_rd_q};
				mul_b = {{2{xsel[15]}}, xsel};
			end
			tma_pkg::ST_MT_AGE_RD: a_re = 1'b1;
			tma_pkg::ST_MT_SQ_MUL: begin
				mul_a = {3'd0, m_q};
				mul_b = {2'd0, m_q};
			end
			tma_pkg::ST_MT_LN_MUL: begin
				mul_a = {3'd0, e_q, frac_q};
				mul_b = {2'd0, tma_pkg::LN2_Q16};
			end
			tma_pkg::ST_MT_SC_LO: begin
				mul_a = {1'b0, acc_q[17:0]};
				mul_b = {2'd0, ln_q};
			end
			tma_pkg::ST_MT_SC_HI: begin
				mul_a = {acc_q[35], acc_q[35:18]};
				mul_b = {2'd0, ln_q};
			end
			tma_pkg::ST_AG_RD: a_re = 1'b1;
			tma_pkg::ST_AG_WR: begin
				a_we = 1'b1;
				if (tpl_q[tma_pkg::IDX_W-1:0] == win_q) a_wdata = tma_pkg::AGE_WIN;
				else if (a_rd_q != tma_pkg::AGE_MAX) a_wdata = a_rd_q + 1'b1;
				else a_wdata = a_rd_q;
			end
			default: begin
			end
		endcase
	end

	// template weight memory
	always_ff @(posedge clk) begin
		if (w_we) wmem[w_addr] <= w_wdata;
		if (w_re) w_rd_q <= wmem[w_addr];
	end

	// age memory
	always_ff @(posedge clk) begin
		if (a_we) amem[a_addr] <= a_wdata;
		if (a_re) a_rd_q <= amem[a_addr];
	end

	// control state, count and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tma_pkg::ST_IDLE;
			count_q     <= '0;
			nonrepeat_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) nonrepeat_q <= cfg_wdata;
			if (state_q == tma_pkg::ST_DECODE && act_q == tma_pkg::ACT_CLEAR) begin
				count_q <= '0;
			end else if (state_q == tma_pkg::ST_ADD_AGE) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tma_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					act_q  <= cmd.action;
					x_q[0] <= cmd.component_0;
					x_q[1] <= cmd.component_1;
					x_q[2] <= cmd.component_2;
					x_q[3] <= cmd.component_3;
					x_q[4] <= cmd.component_4;
					x_q[5] <= cmd.component_5;
					x_q[6] <= cmd.component_6;
					x_q[7] <= cmd.component_7;
					x_q[8] <= cmd.component_8;
					x_q[9] <= cmd.component_9;
				end
			end
			tma_pkg::ST_DECODE: begin
				status_q <= (act_q == tma_pkg::ACT_ADD) && table_full;
				found_q  <= 1'b0;
				best_q   <= '0;
				tpl_q    <= '0;
				cyc_q    <= '0;
				acc_q    <= '0;
			end
			tma_pkg::ST_ADD_SQ: begin
				cyc_q <= cyc_q + 1'b1;
				if (cyc_q != '0) acc_q <= acc_q + tma_pkg::ACC_W'(mul_p);
			end
			tma_pkg::ST_ADD_RSTART: elem_q <= '0;
			tma_pkg::ST_ADD_WR: elem_q <= elem_q + 1'b1;
			tma_pkg::ST_MT_NEXT: begin
				cyc_q <= '0;
				acc_q <= '0;
				if (tpl_q == count_q) tpl_q <= '0;
			end
			tma_pkg::ST_MT_DOT: begin
				cyc_q <= cyc_q + 1'b1;
				if (cyc_q >= tma_pkg::CYC_W'(2)) acc_q <= acc_q + tma_pkg::ACC_W'(mul_p);
			end
			tma_pkg::ST_MT_POST: score_q <= tma_pkg::SCORE_W'(acc_q);
			tma_pkg::ST_MT_AGE_LD: begin
				e_q    <= e_c;
				m_q    <= m_c;
				frac_q <= '0;
				iter_q <= '0;
				ln_q   <= '0;
			end
			tma_pkg::ST_MT_SQ_NORM: begin
				iter_q <= iter_q + 1'b1;
				if (sq_t[16]) begin
					m_q    <= sq_t[16:1];
					frac_q <= {frac_q[tma_pkg::LN_FRAC-2:0], 1'b1};
				end else begin
					m_q    <= sq_t[15:0];
					frac_q <= {frac_q[tma_pkg::LN_FRAC-2:0], 1'b0};
				end
			end
			tma_pkg::ST_MT_LN_RND: ln_q <= ln_rnd[31:16];
			tma_pkg::ST_MT_SC_HI: score_q <= prod_ext;
			tma_pkg::ST_MT_SC_SUM: begin
				score_q <= score_q + {prod_ext[tma_pkg::SCORE_W-19:0], 18'd0};
			end
			tma_pkg::ST_MT_CMP: begin
				if (score_q > best_q) begin
					best_q  <= score_q;
					win_q   <= tpl_q[tma_pkg::IDX_W-1:0];
					found_q <= 1'b1;
				end
				tpl_q <= tpl_q + 1'b1;
			end
			tma_pkg::ST_AG_WR: tpl_q <= tpl_q + 1'b1;
			default: begin
			end
		endcase
	end

	// result channel
	assign win_ext = {{tma_pkg::OUT_W{1'b0}}, win_q};
	assign cnt_ext = {{tma_pkg::OUT_W{1'b0}}, count_q};

	assign cmd.ready        = (state_q == tma_pkg::ST_IDLE);
	assign res.valid        = (state_q == tma_pkg::ST_RESP);
	assign res.best_index   = (act_q == tma_pkg::ACT_MATCH && found_q)
	                          ? win_ext[tma_pkg::OUT_W-1:0] : {tma_pkg::OUT_W{1'b1}};
	assign res.status       = status_q;
	assign res.stored_count = cnt_ext[tma_pkg::OUT_W-1:0];

endmodule

`default_nettype wire

### hdl/tma_mul.sv
// ----------------------------------------------------------------------------
// tma_mul: shared signed multiplier
// one product per cycle, registered output
// ----------------------------------------------------------------------------
`default_nettype none

module tma_mul (
	input  wire logic                             clk,
	input  wire logic signed [tma_pkg::MA_W-1:0]  a,
	input  wire logic signed [tma_pkg::MB_W-1:0]  b,
	output logic signed [tma_pkg::MP_W-1:0]       p
);

	// product register
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

`default_nettype wire

### hdl/tma_rootdiv.sv
// ----------------------------------------------------------------------------
// tma_rootdiv: bit-serial square root and divider
// one root bit or one quotient bit per cycle; the divisor is the last root
// ----------------------------------------------------------------------------
`default_nettype none

module tma_rootdiv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tma_pkg::rd_ctl_t            ctl,
	input  wire logic [33:0]                 sq,
	input  wire logic [15:0]                 mag,
	output logic                             done,
	output logic [15:0]                      quot
);

	logic                        busy_q;
	logic                        div_mode_q;
	logic                        done_q;
	logic [tma_pkg::STEP_W-1:0]  cnt_q;
	logic [63:0]                 v_q;
	logic [63:0]                 r_q;
	logic [63:0]                 bit_q;
	logic [32:0]                 rem_q;
	logic [15:0]                 q_q;

	logic [63:0] trial;
	logic [32:0] rem2;
	logic [32:0] divisor;

	assign trial   = r_q + bit_q;
	assign rem2    = {rem_q[31:0], 1'b0};
	assign divisor = {1'b0, r_q[31:0]};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			div_mode_q <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start_root) begin
				busy_q     <= 1'b1;
				div_mode_q <= 1'b0;
				cnt_q      <= tma_pkg::STEP_W'(tma_pkg::ROOT_STEPS - 1);
			end else if (ctl.start_div) begin
				busy_q     <= 1'b1;
				div_mode_q <= 1'b1;
				cnt_q      <= tma_pkg::STEP_W'(tma_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// root and quotient recurrences
	always_ff @(posedge clk) begin
		if (ctl.start_root) begin
			v_q   <= {2'b00, sq, 28'd0};
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (ctl.start_div) begin
			rem_q <= {4'd0, mag, 13'd0};
			q_q   <= '0;
		end else if (busy_q) begin
			if (!div_mode_q) begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				if (rem2 >= divisor) begin
					rem_q <= rem2 - divisor;
					q_q   <= {q_q[14:0], 1'b1};
				end else begin
					rem_q <= rem2;
					q_q   <= {q_q[14:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

`default_nettype wire
